// ----- src/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants for the HPACK string literal parser
// Holds parser phases, error codes, beat and result structs, field constants.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;

  localparam logic [6:0] PREFIX_MASK = 7'h7f;
  localparam int         CONT_BIT    = 7;
  localparam logic [6:0] SHIFT_STEP  = 7'd7;
  localparam logic [6:0] SHIFT_SAT   = 7'd63;
  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5a;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CONT = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_UPPER = 2'd2,
    ERR_OVF   = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       key_mode;
    logic       block_end;
  } beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       huffman_coded;
    logic       string_done;
    err_t       error_code;
  } res_t;

endpackage

// ----- src/hsp_in_reg.sv -----
// ----------------------------------------------------------------------------
// hsp_in_reg: input register stage
// Captures one input beat and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module hsp_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hsp_pkg::beat_t in_beat,
  input  logic          advance,
  output logic          beat_valid,
  output hsp_pkg::beat_t beat
);

  assign in_ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat <= in_beat;
    end
  end

endmodule

// ----- src/hsp_core.sv -----
// ----------------------------------------------------------------------------
// hsp_core: string literal parse state and per-byte decode logic
// Tracks phase, length accumulation and body count; computes one result per beat.
// ----------------------------------------------------------------------------
module hsp_core #(
  parameter int LENGTH_BITS = hsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  hsp_pkg::beat_t         beat,
  output hsp_pkg::res_t          res,
  output logic [LENGTH_BITS-1:0] res_length
);

  localparam int         SUM_BITS    = LENGTH_BITS + 7;
  localparam logic [5:0] SHIFT_LIMIT = 6'(LENGTH_BITS);

  hsp_pkg::phase_t        phase, phase_next;
  logic                   huffman_flag, huffman_flag_next;
  logic                   name_check, name_check_next;
  logic [LENGTH_BITS-1:0] length_acc, length_acc_next;
  logic [5:0]             shift_amount, shift_amount_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;

  logic [6:0]             chunk;
  logic [SUM_BITS-1:0]    sum;
  logic [6:0]             shift_inc;
  logic [LENGTH_BITS-1:0] left_dec;
  logic                   is_upper;

  assign chunk     = beat.in_byte[6:0];
  assign sum       = {7'd0, length_acc} + ({{LENGTH_BITS{1'b0}}, chunk} << shift_amount);
  assign shift_inc = {1'b0, shift_amount} + hsp_pkg::SHIFT_STEP;
  assign left_dec  = bytes_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign is_upper  = (beat.in_byte >= hsp_pkg::UPPER_FIRST) &&
                     (beat.in_byte <= hsp_pkg::UPPER_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hsp_pkg::PH_IDLE;
      huffman_flag <= 1'b0;
      name_check   <= 1'b0;
      length_acc   <= '0;
      shift_amount <= '0;
      bytes_left   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      huffman_flag <= huffman_flag_next;
      name_check   <= name_check_next;
      length_acc   <= length_acc_next;
      shift_amount <= shift_amount_next;
      bytes_left   <= bytes_left_next;
    end
  end

  always_comb begin
    logic go_idle;
    logic ovf;
    go_idle           = 1'b0;
    ovf               = 1'b0;
    phase_next        = phase;
    huffman_flag_next = huffman_flag;
    name_check_next   = name_check;
    length_acc_next   = length_acc;
    shift_amount_next = shift_amount;
    bytes_left_next   = bytes_left;
    res.out_byte      = 8'd0;
    res.data_valid    = 1'b0;
    res.string_done   = 1'b0;
    res.error_code    = hsp_pkg::ERR_NONE;
    res_length        = '0;

    unique case (phase)
      hsp_pkg::PH_CONT: begin
        if (shift_amount >= SHIFT_LIMIT) begin
          ovf = (chunk != 7'd0);
        end else begin
          ovf = |sum[SUM_BITS-1:LENGTH_BITS];
          if (!ovf) begin
            length_acc_next = sum[LENGTH_BITS-1:0];
          end
        end
        shift_amount_next = (shift_inc > hsp_pkg::SHIFT_SAT) ?
                            hsp_pkg::SHIFT_SAT[5:0] : shift_inc[5:0];
        if (ovf) begin
          res.error_code = hsp_pkg::ERR_OVF;
          go_idle        = 1'b1;
        end else if (!beat.in_byte[hsp_pkg::CONT_BIT]) begin
          res_length      = length_acc_next;
          bytes_left_next = length_acc_next;
          phase_next      = hsp_pkg::PH_BODY;
          if (beat.block_end) begin
            res.error_code = hsp_pkg::ERR_TRUNC;
            go_idle        = 1'b1;
          end
        end else if (beat.block_end) begin
          res.error_code = hsp_pkg::ERR_TRUNC;
          go_idle        = 1'b1;
        end
      end
      hsp_pkg::PH_BODY: begin
        res_length = length_acc;
        if (name_check && !huffman_flag && is_upper) begin
          res.error_code = hsp_pkg::ERR_UPPER;
          go_idle        = 1'b1;
        end else begin
          res.out_byte    = beat.in_byte;
          res.data_valid  = 1'b1;
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            res.string_done = 1'b1;
            go_idle         = 1'b1;
          end else if (beat.block_end) begin
            res.error_code = hsp_pkg::ERR_TRUNC;
            go_idle        = 1'b1;
          end
        end
      end
      default: begin
        // first byte of a string: flag, name check and length prefix
        huffman_flag_next = beat.in_byte[hsp_pkg::CONT_BIT];
        name_check_next   = beat.key_mode;
        shift_amount_next = '0;
        if (chunk == hsp_pkg::PREFIX_MASK) begin
          length_acc_next = LENGTH_BITS'(hsp_pkg::PREFIX_MASK);
          phase_next      = hsp_pkg::PH_CONT;
          if (beat.block_end) begin
            res.error_code = hsp_pkg::ERR_TRUNC;
            go_idle        = 1'b1;
          end
        end else if (chunk == 7'd0) begin
          res.string_done = 1'b1;
          go_idle         = 1'b1;
        end else begin
          length_acc_next = LENGTH_BITS'(chunk);
          bytes_left_next = LENGTH_BITS'(chunk);
          res_length      = LENGTH_BITS'(chunk);
          phase_next      = hsp_pkg::PH_BODY;
          if (beat.block_end) begin
            res.error_code = hsp_pkg::ERR_TRUNC;
            go_idle        = 1'b1;
          end
        end
      end
    endcase

    if (go_idle) begin
      phase_next        = hsp_pkg::PH_IDLE;
      length_acc_next   = '0;
      shift_amount_next = '0;
      bytes_left_next   = '0;
    end
    res.huffman_coded = huffman_flag_next;
  end

endmodule

// ----- src/hsp_out_reg.sv -----
// ----------------------------------------------------------------------------
// hsp_out_reg: result register stage
// Holds one result beat until the receiver takes it; frees itself on handoff.
// ----------------------------------------------------------------------------
module hsp_out_reg #(
  parameter int LENGTH_BITS = hsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  input  hsp_pkg::res_t          load_res,
  input  logic [LENGTH_BITS-1:0] load_length,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hsp_pkg::res_t          res,
  output logic [LENGTH_BITS-1:0] res_length
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      res        <= load_res;
      res_length <= load_length;
    end
  end

endmodule

// ----- src/hpack_string_literal_parser.sv -----
// ----------------------------------------------------------------------------
// hpack_string_literal_parser: HPACK string literal parser, one byte per beat
// Parses the Huffman flag and length prefix, then passes body bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one header-block byte per beat
//   with key_mode (sampled on a string's first byte) and block_end.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat: body byte with data_valid, huffman_coded, string_done,
//   string_length once the prefix is complete, and error_code.
//   Path: an accepted beat is held in the input register, parsed by the
//   combinational core logic, and loads the result register, where
//   out_valid rises.
//   Throughput: one beat per cycle while out_ready is high; the parse
//   logic sits between the two registers and updates its state once per beat.
//   Stall: when out_ready is low with out_valid high the result register
//   holds; the input register takes one more beat only if it is empty,
//   then in_ready drops until the receiver frees the result register.
//   Reset (rst, synchronous): clears both stage valids and returns the parser
//   to waiting for the first byte of a string.
// ----------------------------------------------------------------------------
module hpack_string_literal_parser #(
  parameter int LENGTH_BITS = hsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   key_mode,
  input  logic                   block_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   data_valid,
  output logic                   huffman_coded,
  output logic                   string_done,
  output logic [LENGTH_BITS-1:0] string_length,
  output logic [1:0]             error_code
);

  hsp_pkg::beat_t         in_beat;
  hsp_pkg::beat_t         beat;
  logic                   beat_valid;
  logic                   advance;
  hsp_pkg::res_t          core_res;
  logic [LENGTH_BITS-1:0] core_length;
  hsp_pkg::res_t          res;

  assign in_beat.in_byte   = in_byte;
  assign in_beat.key_mode  = key_mode;
  assign in_beat.block_end = block_end;

  hsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  hsp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (beat_valid && advance),
    .beat       (beat),
    .res        (core_res),
    .res_length (core_length)
  );

  hsp_out_reg #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (beat_valid),
    .load_res    (core_res),
    .load_length (core_length),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res),
    .res_length  (string_length)
  );

  assign out_byte      = res.out_byte;
  assign data_valid    = res.data_valid;
  assign huffman_coded = res.huffman_coded;
  assign string_done   = res.string_done;
  assign error_code    = res.error_code;

endmodule
